### rtl/core/labeling_potts_energy_core_defines.svh
// Assertion macros for the Potts energy core.
`ifndef LABELING_POTTS_ENERGY_CORE_DEFINES_SVH
`define LABELING_POTTS_ENERGY_CORE_DEFINES_SVH

// same-cycle implication
`define LPE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LPE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/lpe_pkg.sv
// Shared constants and types for the Potts energy core.
package lpe_pkg;

  localparam int CFG_INDEX_BITS    = 2;
  localparam int CFG_DATA_BITS     = 13;
  localparam int WIDTH_FIELD_BITS  = 12;
  localparam int HEIGHT_BITS       = 13;
  localparam int ROW_BITS          = 12;
  localparam int MAX_HEIGHT        = 4096;
  localparam int WIDTH_RESET       = 640;
  localparam int HEIGHT_RESET      = 480;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COLOR_ENABLE = 2'd2;

  localparam int LABEL_FIELD_BITS  = 16;
  localparam int WEIGHT_FIELD_BITS = 16;
  localparam int PIX_BITS          = 8;
  localparam int IN_TDATA_BITS     = 96;
  localparam int OUT_TDATA_BITS    = 120;
  localparam int SUM_BITS          = 40;

  // 1/sqrt(2) as an unsigned fixed-point fraction, in units of 2^-24
  localparam int                DIAG_SHIFT = 24;
  localparam logic [23:0]       DIAG_SCALE = 24'd11863283;

  localparam int                DATA_BITS  = 4;
  localparam logic [DATA_BITS-1:0] DATA_CLAMP = 4'd15;

  typedef struct packed {
    logic valid;
    logic last;
  } lpe_ctrl_t;

  typedef struct packed {
    lpe_ctrl_t b;
    logic      res_valid;
  } lpe_stat_t;

endpackage

### rtl/core/lpe_ram.sv
// Simple dual-port RAM, one write and one registered read port.
module lpe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/lpe_front.sv
// Pixel front end: config registers, raster counters, line buffer and neighbor compare.
module lpe_front #(
  parameter int MAX_WIDTH = 2048,
  parameter int LBITS     = 16,
  parameter int WBITS     = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [lpe_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [lpe_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [lpe_pkg::IN_TDATA_BITS-1:0]   s_tdata,
  input  logic                                adv,
  output lpe_pkg::lpe_ctrl_t                  a_ctrl,
  output logic [WBITS-1:0]                    a_h,
  output logic [WBITS-1:0]                    a_v,
  output logic [WBITS-1:0]                    a_b,
  output logic [WBITS-1:0]                    a_f,
  output logic [lpe_pkg::DATA_BITS-1:0]       a_d
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CW1   = CW + 1;
  localparam int RW    = LBITS + 3 * WBITS;
  localparam int W_RST = (lpe_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : lpe_pkg::WIDTH_RESET;

  // record layout, low to high: fwd, back, vert, label
  localparam int F_LO = 0;
  localparam int B_LO = WBITS;
  localparam int V_LO = 2 * WBITS;
  localparam int L_LO = 3 * WBITS;

  logic [CW1-1:0]                   w_lim;
  logic [lpe_pkg::HEIGHT_BITS-1:0]  h_lim;
  logic                             color_en;
  logic [CW1-1:0]                   w_clamp;
  logic [lpe_pkg::HEIGHT_BITS-1:0]  h_clamp;

  logic [CW-1:0]                    col;
  logic [lpe_pkg::ROW_BITS-1:0]     row;
  logic [LBITS-1:0]                 left_label;
  logic [WBITS-1:0]                 left_hw;
  logic [LBITS-1:0]                 upleft_label;
  logic [WBITS-1:0]                 upleft_bw;
  logic [RW-1:0]                    up_q;
  logic [RW-1:0]                    first0;
  logic [RW-1:0]                    first1;
  logic [RW-1:0]                    rd_data;

  logic                             accept;
  logic [LBITS-1:0]                 lab;
  logic [WBITS-1:0]                 hw, vw, bw, fw;
  logic [lpe_pkg::PIX_BITS-1:0]     pix, seed, diff;
  logic [RW-1:0]                    rec, up_rec, ur_rec;
  logic                             x_zero, has_up, last_col, last_row, has_ur;
  logic [CW-1:0]                    raddr;

  assign s_tready = adv;
  assign accept   = s_tvalid && adv;

  assign lab  = s_tdata[LBITS-1:0];
  assign pix  = s_tdata[23:16];
  assign seed = s_tdata[31:24];
  assign hw   = s_tdata[32 +: WBITS];
  assign vw   = s_tdata[48 +: WBITS];
  assign bw   = s_tdata[64 +: WBITS];
  assign fw   = s_tdata[80 +: WBITS];
  assign rec  = {lab, vw, bw, fw};

  always_comb begin
    if (cfg_data[lpe_pkg::WIDTH_FIELD_BITS-1:0] == '0) begin
      w_clamp = CW1'(1);
    end else if (32'(cfg_data[lpe_pkg::WIDTH_FIELD_BITS-1:0]) > MAX_WIDTH) begin
      w_clamp = CW1'(MAX_WIDTH);
    end else begin
      w_clamp = CW1'(cfg_data[lpe_pkg::WIDTH_FIELD_BITS-1:0]);
    end
    if (cfg_data == '0) begin
      h_clamp = lpe_pkg::HEIGHT_BITS'(1);
    end else if (32'(cfg_data) > lpe_pkg::MAX_HEIGHT) begin
      h_clamp = lpe_pkg::HEIGHT_BITS'(lpe_pkg::MAX_HEIGHT);
    end else begin
      h_clamp = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_lim    <= CW1'(W_RST);
      h_lim    <= lpe_pkg::HEIGHT_BITS'(lpe_pkg::HEIGHT_RESET);
      color_en <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpe_pkg::REG_FRAME_WIDTH:  w_lim    <= w_clamp;
        lpe_pkg::REG_FRAME_HEIGHT: h_lim    <= h_clamp;
        lpe_pkg::REG_COLOR_ENABLE: color_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // upper and upper-right entries: column 0 comes from the mirrors
  assign x_zero   = (col == '0);
  assign up_rec   = x_zero ? first0 : up_q;
  assign ur_rec   = x_zero ? first1 : rd_data;
  assign has_up   = (row != '0);
  assign last_col = (CW1'(col) + CW1'(1)) >= w_lim;
  assign last_row = (lpe_pkg::HEIGHT_BITS'(row) + lpe_pkg::HEIGHT_BITS'(1)) >= h_lim;
  assign has_ur   = has_up && !last_col;
  assign diff     = (pix > seed) ? (pix - seed) : (seed - pix);
  assign raddr    = col + CW'(2);

  lpe_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata (rec),
    .re    (accept),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      col          <= '0;
      row          <= '0;
      a_ctrl.valid <= 1'b0;
      a_ctrl.last  <= 1'b0;
    end else if (adv) begin
      a_ctrl.valid <= accept;
      if (accept) begin
        a_ctrl.last <= last_col && last_row;
        if (last_col) begin
          col <= '0;
          row <= last_row ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_h <= (!x_zero && lab != left_label) ? left_hw : '0;
      a_v <= (has_up && lab != up_rec[L_LO +: LBITS]) ? up_rec[V_LO +: WBITS] : '0;
      a_b <= (has_up && !x_zero && lab != upleft_label) ? upleft_bw : '0;
      a_f <= (has_ur && lab != ur_rec[L_LO +: LBITS]) ? ur_rec[F_LO +: WBITS] : '0;
      if (!color_en) begin
        a_d <= '0;
      end else if (diff > lpe_pkg::PIX_BITS'(lpe_pkg::DATA_CLAMP)) begin
        a_d <= lpe_pkg::DATA_CLAMP;
      end else begin
        a_d <= diff[lpe_pkg::DATA_BITS-1:0];
      end
      left_label   <= lab;
      left_hw      <= hw;
      upleft_label <= up_rec[L_LO +: LBITS];
      upleft_bw    <= up_rec[B_LO +: WBITS];
      up_q         <= ur_rec;
      if (x_zero) begin
        first0 <= rec;
      end
      if (col == CW'(1)) begin
        first1 <= rec;
      end
    end
  end

endmodule

### rtl/core/lpe_accum.sv
// Diagonal scaling, frame accumulators, result register and output stage.
module lpe_accum #(
  parameter int WBITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  lpe_pkg::lpe_ctrl_t                  a_ctrl,
  input  logic [WBITS-1:0]                    a_h,
  input  logic [WBITS-1:0]                    a_v,
  input  logic [WBITS-1:0]                    a_b,
  input  logic [WBITS-1:0]                    a_f,
  input  logic [lpe_pkg::DATA_BITS-1:0]       a_d,
  output logic                                adv,
  output lpe_pkg::lpe_stat_t                  stat,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [lpe_pkg::OUT_TDATA_BITS-1:0]  m_tdata
);

  localparam int PW = WBITS + lpe_pkg::DIAG_SHIFT;
  localparam int AW = WBITS + 2;
  localparam int SB = lpe_pkg::SUM_BITS;

  logic [PW-1:0]                  prod_b, prod_f;
  logic [AW-1:0]                  b_add;
  logic [lpe_pkg::DATA_BITS-1:0]  b_d;
  lpe_pkg::lpe_ctrl_t             b_ctrl;
  logic [SB-1:0]                  smooth_sum, data_sum, smooth_new, data_new;
  logic [SB:0]                    smooth_wide, total_wide;
  logic                           res_valid, res_take, res_load;
  logic [SB-1:0]                  res_smooth, res_data;
  logic                           out_valid;
  logic [SB-1:0]                  out_total, out_smooth, out_data;

  assign prod_b = PW'(a_b) * PW'(lpe_pkg::DIAG_SCALE);
  assign prod_f = PW'(a_f) * PW'(lpe_pkg::DIAG_SCALE);

  // hold the pipe only when a frame end meets a result register that cannot drain
  assign res_take = res_valid && (!out_valid || m_tready);
  assign adv      = !(b_ctrl.valid && b_ctrl.last && res_valid && !res_take);
  assign res_load = adv && b_ctrl.valid && b_ctrl.last;

  assign smooth_wide = {1'b0, smooth_sum} + (SB + 1)'(b_add);
  assign smooth_new  = smooth_wide[SB] ? '1 : smooth_wide[SB-1:0];
  assign data_new    = data_sum + SB'(b_d);   // bounded by frame size, cannot wrap
  assign total_wide  = {1'b0, res_smooth} + {1'b0, res_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_ctrl.valid <= 1'b0;
      b_ctrl.last  <= 1'b0;
      smooth_sum   <= '0;
      data_sum     <= '0;
      res_valid    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (adv) begin
        b_ctrl <= a_ctrl;
        if (b_ctrl.valid) begin
          if (b_ctrl.last) begin
            smooth_sum <= '0;
            data_sum   <= '0;
          end else begin
            smooth_sum <= smooth_new;
            data_sum   <= data_new;
          end
        end
      end
      res_valid <= (res_valid && !res_take) || res_load;
      out_valid <= res_take || (out_valid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_ctrl.valid) begin
      b_add <= AW'(a_h) + AW'(a_v) + AW'(prod_b[PW-1:lpe_pkg::DIAG_SHIFT])
             + AW'(prod_f[PW-1:lpe_pkg::DIAG_SHIFT]);
      b_d   <= a_d;
    end
    if (res_load) begin
      res_smooth <= smooth_new;
      res_data   <= data_new;
    end
    if (res_take) begin
      out_total  <= total_wide[SB] ? '1 : total_wide[SB-1:0];
      out_smooth <= res_smooth;
      out_data   <= res_data;
    end
  end

  assign stat.b         = b_ctrl;
  assign stat.res_valid = res_valid;
  assign m_tvalid       = out_valid;
  assign m_tdata        = {out_data, out_smooth, out_total};

endmodule

### rtl/core/labeling_potts_energy_core.sv
// Top level of the 8-connected Potts energy core.
//
// Takes one labeled pixel per clock in raster order and sustains one pixel per
// cycle; input is held off only while a frame end waits behind the previous
// frame's result, and that lasts for as long as the output stream stalls with
// both the result and the output register full. Each pixel
// charges the edge weights of its left, upper, upper-left and upper-right
// neighbors whose labels differ (diagonals scaled by 1/sqrt(2), floored), plus
// an optional clamped seed color difference. The frame result (total and smooth
// energy saturating at 2^40-1, data energy bounded by the frame size) passes
// through neighbor compare, diagonal scaling, accumulation into the result
// register and the output register, in that order, before it is valid on the
// output stream. The previous row lives in one MAX_WIDTH-deep
// line buffer RAM written and read once per pixel; there is no
// clearing pass. Frame geometry is clamped on write (width 1..MAX_WIDTH,
// height 1..4096) and should be changed only between frames.
module labeling_potts_energy_core #(
  parameter int MAX_WIDTH   = 2048,
  parameter int LABEL_BITS  = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [lpe_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [lpe_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // label[15:0], pixel_intensity[23:16], seed_intensity[31:24], horiz_weight[47:32],
  // vert_weight[63:48], diag_back_weight[79:64], diag_fwd_weight[95:80]
  input  logic [lpe_pkg::IN_TDATA_BITS-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // energy_total[39:0], energy_smooth[79:40], energy_data[119:80]
  output logic [lpe_pkg::OUT_TDATA_BITS-1:0]  m_tdata
);

`include "labeling_potts_energy_core_defines.svh"

  localparam int LB = (LABEL_BITS < lpe_pkg::LABEL_FIELD_BITS) ?
                      LABEL_BITS : lpe_pkg::LABEL_FIELD_BITS;
  localparam int WB = (WEIGHT_BITS < lpe_pkg::WEIGHT_FIELD_BITS) ?
                      WEIGHT_BITS : lpe_pkg::WEIGHT_FIELD_BITS;

  lpe_pkg::lpe_ctrl_t             a_ctrl;
  lpe_pkg::lpe_stat_t             stat;
  logic                           adv;
  logic [WB-1:0]                  a_h, a_v, a_b, a_f;
  logic [lpe_pkg::DATA_BITS-1:0]  a_d;

  lpe_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .LBITS     (LB),
    .WBITS     (WB)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .adv       (adv),
    .a_ctrl    (a_ctrl),
    .a_h       (a_h),
    .a_v       (a_v),
    .a_b       (a_b),
    .a_f       (a_f),
    .a_d       (a_d)
  );

  lpe_accum #(
    .WBITS (WB)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .a_ctrl   (a_ctrl),
    .a_h      (a_h),
    .a_v      (a_v),
    .a_b      (a_b),
    .a_f      (a_f),
    .a_d      (a_d),
    .adv      (adv),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  `LPE_ASSERT_NOW(a_out_from_result, $rose(m_tvalid), $past(stat.res_valid), "output without result")
  `LPE_ASSERT_NEXT(a_last_moves, a_ctrl.valid && a_ctrl.last && adv, stat.b.valid && stat.b.last, "frame end lost")
  `LPE_ASSERT_NOW(a_total_ge_smooth, m_tvalid, m_tdata[39:0] >= m_tdata[79:40], "total below smooth")

endmodule

### tb/tb_labeling_potts_energy_core.sv
// Self-checking testbench for the Potts energy core: streams labeled frames, checks frame energies.
module tb_labeling_potts_energy_core;

  localparam int LINE_DEPTH   = 2048;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT  = 5000;
  localparam logic [lpe_pkg::CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [lpe_pkg::SUM_BITS-1:0] total;
    logic [lpe_pkg::SUM_BITS-1:0] smooth;
    logic [lpe_pkg::SUM_BITS-1:0] data;
  } energy_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [lpe_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [lpe_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // label[15:0], pixel_intensity[23:16], seed_intensity[31:24], horiz_weight[47:32],
  // vert_weight[63:48], diag_back_weight[79:64], diag_fwd_weight[95:80]
  logic [lpe_pkg::IN_TDATA_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // energy_total[39:0], energy_smooth[79:40], energy_data[119:80]
  logic [lpe_pkg::OUT_TDATA_BITS-1:0] m_tdata;

  logic calm = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  // predictor state
  logic [11:0] cfg_width = 12'd640;
  logic [12:0] cfg_height = 13'd480;
  logic color_on = 1'b0;
  logic [15:0] line_label [LINE_DEPTH];
  logic [15:0] line_vert [LINE_DEPTH];
  logic [15:0] line_back [LINE_DEPTH];
  logic [15:0] line_fwd [LINE_DEPTH];
  logic [15:0] left_lab = '0;
  logic [15:0] left_hw = '0;
  logic [15:0] ul_lab = '0;
  logic [15:0] ul_bw = '0;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  logic [lpe_pkg::SUM_BITS-1:0] smooth_acc = '0;
  logic [lpe_pkg::SUM_BITS-1:0] data_acc = '0;
  energy_t energy_q [$];

  labeling_potts_energy_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 7);
  end

  function automatic int unsigned eff_width();
    int unsigned v;
    v = 32'(cfg_width);
    if (v < 1) v = 1;
    if (v > LINE_DEPTH) v = LINE_DEPTH;
    return v;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned v;
    v = 32'(cfg_height);
    if (v < 1) v = 1;
    if (v > lpe_pkg::MAX_HEIGHT) v = 32'(lpe_pkg::MAX_HEIGHT);
    return v;
  endfunction

  function automatic logic [lpe_pkg::SUM_BITS-1:0] sat_sum(
      input logic [lpe_pkg::SUM_BITS-1:0] a, input logic [lpe_pkg::SUM_BITS-1:0] b);
    logic [lpe_pkg::SUM_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[lpe_pkg::SUM_BITS] ? {lpe_pkg::SUM_BITS{1'b1}} : s[lpe_pkg::SUM_BITS-1:0];
  endfunction

  function automatic logic [15:0] diag_part(input logic [15:0] wgt);
    logic [39:0] p;
    p = 40'(wgt) * 40'(lpe_pkg::DIAG_SCALE);
    return 16'(p >> lpe_pkg::DIAG_SHIFT);
  endfunction

  function automatic void predict_pixel(input logic [lpe_pkg::IN_TDATA_BITS-1:0] word);
    logic [15:0] lab, hw, vw, bw, fw;
    logic [7:0] pix, seed, diff;
    logic [lpe_pkg::SUM_BITS-1:0] charge;
    int unsigned w, h, x, y;
    energy_t e;
    lab = word[15:0];
    pix = word[23:16];
    seed = word[31:24];
    hw = word[47:32];
    vw = word[63:48];
    bw = word[79:64];
    fw = word[95:80];
    w = eff_width();
    h = eff_height();
    x = (col_pos >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_pos;
    y = row_pos;
    charge = '0;
    if (x > 0 && lab != left_lab) charge = charge + lpe_pkg::SUM_BITS'(left_hw);
    if (y > 0) begin
      if (lab != line_label[x]) charge = charge + lpe_pkg::SUM_BITS'(line_vert[x]);
      if (x > 0 && lab != ul_lab) charge = charge + lpe_pkg::SUM_BITS'(diag_part(ul_bw));
      if (x + 1 < w && x + 1 < LINE_DEPTH && lab != line_label[x + 1])
        charge = charge + lpe_pkg::SUM_BITS'(diag_part(line_fwd[x + 1]));
    end
    smooth_acc = sat_sum(smooth_acc, charge);
    if (color_on) begin
      diff = (pix > seed) ? pix - seed : seed - pix;
      if (diff > 8'(lpe_pkg::DATA_CLAMP)) diff = 8'(lpe_pkg::DATA_CLAMP);
      data_acc = sat_sum(data_acc, lpe_pkg::SUM_BITS'(diff));
    end
    ul_lab = line_label[x];
    ul_bw = line_back[x];
    line_label[x] = lab;
    line_vert[x] = vw;
    line_back[x] = bw;
    line_fwd[x] = fw;
    left_lab = lab;
    left_hw = hw;
    if (x + 1 < w) begin
      col_pos = x + 1;
      return;
    end
    col_pos = 0;
    if (y + 1 < h) begin
      row_pos = y + 1;
      return;
    end
    row_pos = 0;
    e.total = sat_sum(smooth_acc, data_acc);
    e.smooth = smooth_acc;
    e.data = data_acc;
    energy_q.push_back(e);
    smooth_acc = '0;
    data_acc = '0;
  endfunction

  function automatic logic [lpe_pkg::IN_TDATA_BITS-1:0] pack_pixel(
      input logic [15:0] lab, input logic [7:0] pix, input logic [7:0] seed,
      input logic [15:0] hw, input logic [15:0] vw, input logic [15:0] bw,
      input logic [15:0] fw);
    return {fw, bw, vw, hw, seed, pix, lab};
  endfunction

  // labels cluster around a base so neighbors often match
  function automatic logic [lpe_pkg::IN_TDATA_BITS-1:0] random_pixel(input logic [15:0] base);
    logic [15:0] lab;
    logic [7:0] pix, seed;
    if ($urandom_range(9) < 7) lab = base + 16'($urandom_range(2));
    else lab = 16'($urandom);
    pix = 8'($urandom);
    if ($urandom_range(1) == 1) seed = pix + 8'($urandom_range(20)) - 8'd10;
    else seed = 8'($urandom);
    return pack_pixel(lab, pix, seed, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
  endfunction

  task automatic send_pixel(input logic [lpe_pkg::IN_TDATA_BITS-1:0] word);
    while (!calm && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_pixel(word);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (energy_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lpe_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [lpe_pkg::CFG_DATA_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      lpe_pkg::REG_FRAME_WIDTH: cfg_width = val[11:0];
      lpe_pkg::REG_FRAME_HEIGHT: cfg_height = val[12:0];
      lpe_pkg::REG_COLOR_ENABLE: color_on = val[0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input logic [12:0] w_val, input logic [12:0] h_val,
                              input logic [12:0] color_val);
    wait_idle();
    write_reg(lpe_pkg::REG_FRAME_WIDTH, w_val);
    write_reg(lpe_pkg::REG_FRAME_HEIGHT, h_val);
    write_reg(lpe_pkg::REG_COLOR_ENABLE, color_val);
  endtask

  task automatic send_random_frame(input logic [15:0] base);
    int unsigned n;
    n = eff_width() * eff_height();
    repeat (n) send_pixel(random_pixel(base));
  endtask

  // color term left at its reset value
  task automatic test_reset_color_off();
    write_reg(lpe_pkg::REG_FRAME_WIDTH, 13'd3);
    write_reg(lpe_pkg::REG_FRAME_HEIGHT, 13'd2);
    send_pixel(pack_pixel(16'h0000, 8'd0, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(pack_pixel(16'hFFFF, 8'd255, 8'd0, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
    send_pixel(pack_pixel(16'hFFFF, 8'd255, 8'd255, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
    send_pixel(pack_pixel(16'hFFFF, 8'd17, 8'd200, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(pack_pixel(16'h0000, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(pack_pixel(16'h0000, 8'd128, 8'd1, 16'h0001, 16'h0001, 16'h0001, 16'h0001));
  endtask

  // clamp, reverse clamp, small and zero differences
  task automatic test_data_term();
    set_geometry(13'h1004, 13'd1, 13'd1);
    send_pixel(pack_pixel(16'd5, 8'd0, 8'd255, 16'hFFFF, 16'h1234, 16'h0000, 16'hFFFF));
    send_pixel(pack_pixel(16'd5, 8'd255, 8'd0, 16'h0001, 16'hABCD, 16'hFFFF, 16'h0000));
    send_pixel(pack_pixel(16'd6, 8'd100, 8'd90, 16'h0002, 16'h5555, 16'hAAAA, 16'h5555));
    send_pixel(pack_pixel(16'hFFFF, 8'd7, 8'd7, 16'h0003, 16'hAAAA, 16'h5555, 16'hAAAA));
  endtask

  // zero width and height clamp to one; upper register bits ignored
  task automatic test_clamped_geometry();
    set_geometry(13'd0, 13'd0, 13'h0002);
    write_reg(REG_UNUSED, 13'h1FFF);
    send_pixel(pack_pixel(16'h8000, 8'd3, 8'd250, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_pixel(pack_pixel(16'h7FFF, 8'd250, 8'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
  endtask

  // bottom row repeats the first two labels of the middle one, so only its last pixel adds a vertical charge
  task automatic test_diagonals();
    set_geometry(13'd3, 13'd3, 13'h1FFF);
    send_pixel(pack_pixel(16'd10, 8'd20, 8'd30, 16'h8000, 16'h0001, 16'hFFFF, 16'hFFFF));
    send_pixel(pack_pixel(16'd11, 8'd40, 8'd38, 16'h8000, 16'h0001, 16'hFFFF, 16'hFFFF));
    send_pixel(pack_pixel(16'd12, 8'd90, 8'd60, 16'h8000, 16'h0001, 16'h0001, 16'h0001));
    send_pixel(pack_pixel(16'd13, 8'd1, 8'd0, 16'h8000, 16'h0001, 16'hFFFF, 16'hFFFF));
    send_pixel(pack_pixel(16'd14, 8'd0, 8'd1, 16'h8000, 16'h0001, 16'h0002, 16'h0002));
    send_pixel(pack_pixel(16'd15, 8'd200, 8'd186, 16'h8000, 16'h0001, 16'hFFFF, 16'hFFFF));
    send_pixel(pack_pixel(16'd13, 8'd201, 8'd186, 16'h8000, 16'h0001, 16'hFFFF, 16'hFFFF));
    send_pixel(pack_pixel(16'd14, 8'd5, 8'd5, 16'h8000, 16'h0001, 16'hFFFF, 16'hFFFF));
    send_pixel(pack_pixel(16'hFFFF, 8'd255, 8'd255, 16'h8000, 16'h0001, 16'hFFFF, 16'hFFFF));
  endtask

  task automatic test_random_frames();
    logic [15:0] base;
    for (int f = 0; f < 50; f++) begin
      if (f == 0 || $urandom_range(9) < 6)
        set_geometry(13'($urandom_range(12, 1)), 13'($urandom_range(6, 1)),
                     13'($urandom_range(1)));
      base = 16'($urandom);
      send_random_frame(base);
    end
  endtask

  // every pixel ends a frame, so results pile up against output stalls
  task automatic test_single_pixel_frames();
    set_geometry(13'd1, 13'd1, 13'd1);
    calm <= 1'b1;
    repeat (40) send_pixel(random_pixel(16'($urandom)));
    calm <= 1'b0;
    repeat (60) send_pixel(random_pixel(16'($urandom)));
  endtask

  task automatic test_wide_frames();
    set_geometry(13'd300, 13'd2, 13'd1);
    calm <= 1'b1;
    send_random_frame(16'($urandom));
    calm <= 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [lpe_pkg::SUM_BITS-1:0] exp_val,
                               input logic [lpe_pkg::SUM_BITS-1:0] act_val);
    if (act_val !== exp_val) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin : check_results
    energy_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (energy_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result item: %h", m_tdata);
      end else begin
        e = energy_q.pop_front();
        compare_field("energy_total", e.total, m_tdata[39:0]);
        compare_field("energy_smooth", e.smooth, m_tdata[79:40]);
        compare_field("energy_data", e.data, m_tdata[119:80]);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    foreach (line_label[i]) begin
      line_label[i] = '0;
      line_vert[i] = '0;
      line_back[i] = '0;
      line_fwd[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_color_off();
    test_data_term();
    test_clamped_geometry();
    test_diagonals();
    test_random_frames();
    test_single_pixel_frames();
    test_wide_frames();
    wait_idle();
    if (mismatch_count == 0 && energy_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
